>>> hw/rtl/lpm_pkg.sv
// Shared types, constants and helper functions for the LPM trie core.
package lpm_pkg;

    localparam int NODE_COUNT = 1024;
    localparam int PEER_BITS  = 8;
    localparam int IDX_W      = $clog2(NODE_COUNT);
    localparam int CHILD_W    = IDX_W + 1;
    localparam int KEY_W      = 128;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_INVALID = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;
    localparam logic [1:0] STAT_MISS    = 2'd3;

    localparam logic [7:0] WIDTH_V4 = 8'd32;
    localparam logic [7:0] WIDTH_V6 = 8'd128;

    typedef struct packed {
        logic        opcode;
        logic        is_v6;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [7:0]  prefix_len;
        logic [7:0]  peer_in;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] peer_out;
    } out_item_t;

    // One trie node; child fields hold index plus one, zero for none
    typedef struct packed {
        logic [KEY_W-1:0]     key;
        logic [7:0]           prefix;
        logic [PEER_BITS-1:0] peer;
        logic [CHILD_W-1:0]   child_zero;
        logic [CHILD_W-1:0]   child_one;
    } node_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        node_t            wr_data;
    } ram_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_LZ1,
        ST_LZ2,
        ST_WR_NEW,
        ST_WR_SPLIT,
        ST_WR_PARENT,
        ST_DONE
    } state_t;

    // Key bit at position pos counted from the MSB; positions past the key read 0
    function automatic logic key_bit(logic [KEY_W-1:0] key, logic [7:0] pos);
        logic r;
        r = pos[7] ? 1'b0 : key[~pos[6:0]];
        return r;
    endfunction

    // True when the top pfx bits of both keys agree
    function automatic logic key_match(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b,
                                       logic [7:0] pfx);
        logic [KEY_W-1:0] mask;
        mask = ~({KEY_W{1'b1}} >> pfx);
        return ((a ^ b) & mask) == '0;
    endfunction

endpackage

>>> hw/rtl/lpm_node_ram.sv
// Node pool memory: one write port, one read port with registered read data.
module lpm_node_ram (
    input  logic              aclk,
    input  lpm_pkg::ram_req_t req,
    output lpm_pkg::node_t    rd_data
);

    lpm_pkg::node_t mem [lpm_pkg::NODE_COUNT];

    // write port
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

>>> hw/rtl/lpm_trie_insert_lookup_core.sv
// Top level: trie walk and insert sequencer around the node pool memory.
// Lookup: one node read per cycle from accept to result,
// depth up to 33 nodes for IPv4 and 129 for IPv6; a root miss skips the walk.
// Insert: walk as above, plus the prefix compare states ST_LZ1 and ST_LZ2 on divergence and 1 to 3 writes.
// One item at a time: s_ready rises with m_valid, so a new item is taken only once the last result is presented.
// Synchronous active-low reset clears root valid flags, free count and control; node memory is kept.
module lpm_trie_insert_lookup_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lpm_pkg::in_item_t   s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output lpm_pkg::out_item_t  m_item
);

    localparam int IW = lpm_pkg::IDX_W;
    localparam int CW = lpm_pkg::CHILD_W;
    localparam int PB = lpm_pkg::PEER_BITS;
    localparam int KW = lpm_pkg::KEY_W;

    lpm_pkg::state_t   state_reg, state_next;
    lpm_pkg::ram_req_t req;
    lpm_pkg::node_t    rd_data;

    logic             op_reg, op_next;
    logic             v6_reg, v6_next;
    logic [KW-1:0]    key_reg, key_next;
    logic [7:0]       plen_reg, plen_next;
    logic [PB-1:0]    peer_reg, peer_next;
    logic [CW-1:0]    nf_reg, nf_next;
    logic             r4v_reg, r4v_next, r6v_reg, r6v_next;
    logic [IW-1:0]    r4_reg, r4_next, r6_reg, r6_next;
    logic [IW-1:0]    node_reg, node_next;
    logic             parv_reg, parv_next;
    logic [IW-1:0]    par_reg, par_next;
    lpm_pkg::node_t   prec_reg, prec_next;
    logic             repl_reg, repl_next;
    logic [IW-1:0]    down_reg, down_next;
    lpm_pkg::node_t   drec_reg, drec_next;
    lpm_pkg::node_t   nn_reg, nn_next;
    lpm_pkg::node_t   sp_reg, sp_next;
    logic             split_reg, split_next;
    logic [IW-1:0]    att_reg, att_next;
    logic [PB-1:0]    found_reg, found_next;
    logic [1:0]       stat_reg, stat_next;
    logic [15:0]      nz_reg, nz_next;
    logic [2:0]       lz_reg [16];
    logic [2:0]       lz_next [16];
    logic             mv_reg, mv_next;
    lpm_pkg::out_item_t mo_reg, mo_next;

    // combinational helpers
    logic [KW-1:0]    in_key;
    logic             in_bad;
    logic             root_ok;
    logic [IW-1:0]    root_idx;
    logic [7:0]       width;
    logic             w_match, w_br, w_ch_ok;
    logic [CW-1:0]    w_ch;
    logic [PB-1:0]    w_found;
    logic [KW-1:0]    lx;
    logic [3:0]       g_sel;
    logic             g_any;
    logic [7:0]       c_all, c2;
    logic             bd;
    logic             pbr;
    lpm_pkg::node_t   pw;
    logic [CW-1:0]    att_code;

    lpm_node_ram u_ram (
        .aclk    (aclk),
        .req     (req),
        .rd_data (rd_data)
    );

    assign s_ready = (state_reg == lpm_pkg::ST_IDLE);
    assign m_valid = mv_reg;
    assign m_item  = mo_reg;

    // state and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lpm_pkg::ST_IDLE;
            nf_reg    <= '0;
            r4v_reg   <= 1'b0;
            r6v_reg   <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            nf_reg    <= nf_next;
            r4v_reg   <= r4v_next;
            r6v_reg   <= r6v_next;
            mv_reg    <= mv_next;
        end
        op_reg    <= op_next;
        v6_reg    <= v6_next;
        key_reg   <= key_next;
        plen_reg  <= plen_next;
        peer_reg  <= peer_next;
        r4_reg    <= r4_next;
        r6_reg    <= r6_next;
        node_reg  <= node_next;
        parv_reg  <= parv_next;
        par_reg   <= par_next;
        prec_reg  <= prec_next;
        repl_reg  <= repl_next;
        down_reg  <= down_next;
        drec_reg  <= drec_next;
        nn_reg    <= nn_next;
        sp_reg    <= sp_next;
        split_reg <= split_next;
        att_reg   <= att_next;
        found_reg <= found_next;
        stat_reg  <= stat_next;
        nz_reg    <= nz_next;
        lz_reg    <= lz_next;
        mo_reg    <= mo_next;
    end

    // input decode
    always_comb begin
        in_key   = s_item.is_v6 ? {s_item.addr_hi, s_item.addr_lo}
                                : {s_item.addr_lo[31:0], {(KW-32){1'b0}}};
        in_bad   = (s_item.prefix_len > (s_item.is_v6 ? lpm_pkg::WIDTH_V6 : lpm_pkg::WIDTH_V4))
                   || (s_item.peer_in[PB-1:0] == '0);
        root_idx = s_item.is_v6 ? r6_reg : r4_reg;
        root_ok  = s_item.is_v6 ? (r6v_reg && ({1'b0, r6_reg} < nf_reg))
                                : (r4v_reg && ({1'b0, r4_reg} < nf_reg));
        width    = v6_reg ? lpm_pkg::WIDTH_V6 : lpm_pkg::WIDTH_V4;
    end

    // walk step on the node just read
    always_comb begin
        w_match = lpm_pkg::key_match(rd_data.key, key_reg, rd_data.prefix);
        w_br    = lpm_pkg::key_bit(key_reg, rd_data.prefix);
        w_ch    = w_br ? rd_data.child_one : rd_data.child_zero;
        w_ch_ok = (w_ch != '0) && (w_ch <= nf_reg);
        w_found = (w_match && rd_data.peer != '0) ? rd_data.peer : found_reg;
    end

    // leading common bits: per-byte nonzero flags and leading-zero counts, then byte select
    always_comb begin
        lx = drec_reg.key ^ key_reg;
        for (int g = 0; g < 16; g++) begin
            nz_next[g] = |lx[KW-1-8*g -: 8];
            lz_next[g] = 3'd0;
            for (int b = 0; b < 8; b++) begin
                if (lx[KW-1-8*g-b] && lz_next[g] == 3'd0 && (b == 0 || lx[KW-1-8*g -: 8] >>
                    (8 - b) == 8'd0)) begin
                    lz_next[g] = 3'(b);
                end
            end
        end
        g_sel = 4'd0;
        g_any = 1'b0;
        for (int g = 15; g >= 0; g--) begin
            if (nz_reg[g]) begin
                g_sel = 4'(g);
                g_any = 1'b1;
            end
        end
        c_all = g_any ? {1'b0, g_sel, lz_reg[g_sel]} : 8'd128;
        c2    = (c_all > plen_reg) ? plen_reg : c_all;
        bd    = lpm_pkg::key_bit(drec_reg.key, c2);
    end

    // parent write data: peer replace or child attach
    always_comb begin
        att_code = CW'(att_reg) + CW'(1);
        pbr      = lpm_pkg::key_bit(key_reg, prec_reg.prefix);
        pw       = prec_reg;
        if (repl_reg) begin
            pw.peer = peer_reg;
        end else if (pbr) begin
            pw.child_one = att_code;
        end else begin
            pw.child_zero = att_code;
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        v6_next    = v6_reg;
        key_next   = key_reg;
        plen_next  = plen_reg;
        peer_next  = peer_reg;
        nf_next    = nf_reg;
        r4v_next   = r4v_reg;
        r6v_next   = r6v_reg;
        r4_next    = r4_reg;
        r6_next    = r6_reg;
        node_next  = node_reg;
        parv_next  = parv_reg;
        par_next   = par_reg;
        prec_next  = prec_reg;
        repl_next  = repl_reg;
        down_next  = down_reg;
        drec_next  = drec_reg;
        nn_next    = nn_reg;
        sp_next    = sp_reg;
        split_next = split_reg;
        att_next   = att_reg;
        found_next = found_reg;
        stat_next  = stat_reg;
        mv_next    = mv_reg && !m_ready;
        mo_next    = mo_reg;
        req        = '0;

        unique case (state_reg)
            lpm_pkg::ST_IDLE: begin
                if (s_valid) begin
                    op_next    = s_item.opcode;
                    v6_next    = s_item.is_v6;
                    key_next   = in_key;
                    plen_next  = s_item.prefix_len;
                    peer_next  = s_item.peer_in[PB-1:0];
                    found_next = '0;
                    parv_next  = 1'b0;
                    repl_next  = 1'b0;
                    split_next = 1'b0;
                    if (s_item.opcode == lpm_pkg::OP_INSERT && in_bad) begin
                        stat_next  = lpm_pkg::STAT_INVALID;
                        state_next = lpm_pkg::ST_DONE;
                    end else if (!root_ok) begin
                        if (s_item.opcode == lpm_pkg::OP_LOOKUP) begin
                            stat_next = lpm_pkg::STAT_MISS;
                            state_next = lpm_pkg::ST_DONE;
                        end else if (nf_reg >= CW'(lpm_pkg::NODE_COUNT)) begin
                            stat_next = lpm_pkg::STAT_FULL;
                            state_next = lpm_pkg::ST_DONE;
                        end else begin
                            nn_next = '{key: in_key, prefix: s_item.prefix_len,
                                        peer: s_item.peer_in[PB-1:0],
                                        child_zero: '0, child_one: '0};
                            att_next   = nf_reg[IW-1:0];
                            state_next = lpm_pkg::ST_WR_NEW;
                        end
                    end else begin
                        req.rd_en   = 1'b1;
                        req.rd_addr = root_idx;
                        node_next   = root_idx;
                        state_next  = lpm_pkg::ST_WALK;
                    end
                end
            end

            lpm_pkg::ST_WALK: begin
                if (op_reg == lpm_pkg::OP_LOOKUP) begin
                    found_next = w_found;
                    if (w_match && rd_data.prefix != width && w_ch_ok) begin
                        req.rd_en   = 1'b1;
                        req.rd_addr = w_ch[IW-1:0] - IW'(1);
                        node_next   = w_ch[IW-1:0] - IW'(1);
                    end else begin
                        stat_next  = (w_found != '0) ? lpm_pkg::STAT_OK : lpm_pkg::STAT_MISS;
                        state_next = lpm_pkg::ST_DONE;
                    end
                end else if (rd_data.prefix <= plen_reg && w_match) begin
                    par_next  = node_reg;
                    prec_next = rd_data;
                    parv_next = 1'b1;
                    if (rd_data.prefix == plen_reg) begin
                        // exact prefix: replace peer in place
                        repl_next  = 1'b1;
                        state_next = lpm_pkg::ST_WR_PARENT;
                    end else if (w_ch_ok) begin
                        req.rd_en   = 1'b1;
                        req.rd_addr = w_ch[IW-1:0] - IW'(1);
                        node_next   = w_ch[IW-1:0] - IW'(1);
                    end else if (nf_reg >= CW'(lpm_pkg::NODE_COUNT)) begin
                        stat_next  = lpm_pkg::STAT_FULL;
                        state_next = lpm_pkg::ST_DONE;
                    end else begin
                        // empty branch: new leaf under this node
                        nn_next = '{key: key_reg, prefix: plen_reg, peer: peer_reg,
                                    child_zero: '0, child_one: '0};
                        att_next   = nf_reg[IW-1:0];
                        state_next = lpm_pkg::ST_WR_NEW;
                    end
                end else begin
                    down_next  = node_reg;
                    drec_next  = rd_data;
                    state_next = lpm_pkg::ST_LZ1;
                end
            end

            lpm_pkg::ST_LZ1: begin
                state_next = lpm_pkg::ST_LZ2;
            end

            lpm_pkg::ST_LZ2: begin
                nn_next = '{key: key_reg, prefix: plen_reg, peer: peer_reg,
                            child_zero: '0, child_one: '0};
                if (c2 == plen_reg) begin
                    // new node sits above the diverging node
                    if (nf_reg >= CW'(lpm_pkg::NODE_COUNT)) begin
                        stat_next  = lpm_pkg::STAT_FULL;
                        state_next = lpm_pkg::ST_DONE;
                    end else begin
                        if (lpm_pkg::key_bit(drec_reg.key, plen_reg)) begin
                            nn_next.child_one = CW'(down_reg) + CW'(1);
                        end else begin
                            nn_next.child_zero = CW'(down_reg) + CW'(1);
                        end
                        att_next   = nf_reg[IW-1:0];
                        state_next = lpm_pkg::ST_WR_NEW;
                    end
                end else if ({1'b0, nf_reg} + (CW+1)'(2) > (CW+1)'(lpm_pkg::NODE_COUNT)) begin
                    stat_next  = lpm_pkg::STAT_FULL;
                    state_next = lpm_pkg::ST_DONE;
                end else begin
                    // split node over the diverging node and the new leaf
                    sp_next = '{key: key_reg, prefix: c2, peer: '0,
                                child_zero: '0, child_one: '0};
                    if (bd) begin
                        sp_next.child_one  = CW'(down_reg) + CW'(1);
                        sp_next.child_zero = nf_reg + CW'(1);
                    end else begin
                        sp_next.child_zero = CW'(down_reg) + CW'(1);
                        sp_next.child_one  = nf_reg + CW'(1);
                    end
                    split_next = 1'b1;
                    att_next   = nf_reg[IW-1:0] + IW'(1);
                    state_next = lpm_pkg::ST_WR_NEW;
                end
            end

            lpm_pkg::ST_WR_NEW: begin
                req.wr_en   = 1'b1;
                req.wr_addr = nf_reg[IW-1:0];
                req.wr_data = nn_reg;
                nf_next     = nf_reg + CW'(1);
                if (split_reg) begin
                    state_next = lpm_pkg::ST_WR_SPLIT;
                end else if (parv_reg) begin
                    state_next = lpm_pkg::ST_WR_PARENT;
                end else begin
                    if (v6_reg) begin
                        r6_next  = att_reg;
                        r6v_next = 1'b1;
                    end else begin
                        r4_next  = att_reg;
                        r4v_next = 1'b1;
                    end
                    stat_next  = lpm_pkg::STAT_OK;
                    state_next = lpm_pkg::ST_DONE;
                end
            end

            lpm_pkg::ST_WR_SPLIT: begin
                req.wr_en   = 1'b1;
                req.wr_addr = nf_reg[IW-1:0];
                req.wr_data = sp_reg;
                nf_next     = nf_reg + CW'(1);
                if (parv_reg) begin
                    state_next = lpm_pkg::ST_WR_PARENT;
                end else begin
                    if (v6_reg) begin
                        r6_next  = att_reg;
                        r6v_next = 1'b1;
                    end else begin
                        r4_next  = att_reg;
                        r4v_next = 1'b1;
                    end
                    stat_next  = lpm_pkg::STAT_OK;
                    state_next = lpm_pkg::ST_DONE;
                end
            end

            lpm_pkg::ST_WR_PARENT: begin
                req.wr_en   = 1'b1;
                req.wr_addr = par_reg;
                req.wr_data = pw;
                stat_next   = lpm_pkg::STAT_OK;
                state_next  = lpm_pkg::ST_DONE;
            end

            lpm_pkg::ST_DONE: begin
                if (!mv_reg || m_ready) begin
                    mv_next          = 1'b1;
                    mo_next.status   = stat_reg;
                    mo_next.peer_out = (op_reg == lpm_pkg::OP_LOOKUP) ? 8'(found_reg) : 8'd0;
                    state_next       = lpm_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = lpm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/lpm_chk.sv
// Port-level checker for the LPM trie core, bound to the top level.
module lpm_chk (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input lpm_pkg::out_item_t m_item
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    // one item at a time: input closes right after an accept
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after an accept");

    // misses and errors carry no peer
    a_miss_peer: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.status == lpm_pkg::STAT_MISS |-> m_item.peer_out == 8'd0)
        else $error("miss with nonzero peer");

    a_err_peer: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_item.status == lpm_pkg::STAT_INVALID ||
                    m_item.status == lpm_pkg::STAT_FULL) |-> m_item.peer_out == 8'd0)
        else $error("error result with nonzero peer");

    // reset drops any pending result
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind lpm_trie_insert_lookup_core lpm_chk u_lpm_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
